### hw/rtl/lphs_pkg.sv
package lphs_pkg;

  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned SIZE_W   = 11;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned ACTION_W = 2;
  localparam int unsigned QDEPTH   = 2;

  typedef enum logic [1:0] {
    ACT_FIND   = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_REMOVE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_EMPTY   = 2'd0,
    ST_USED    = 2'd1,
    ST_DELETED = 2'd2,
    ST_SPARE   = 2'd3
  } slot_st_t;

  typedef enum logic [2:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_READ,
    BK_CHECK,
    BK_WRITE,
    BK_DONE
  } bk_state_t;

  // Classified request handed from front to back.
  typedef struct packed {
    action_t          action;
    logic [KEY_W-1:0] key;
    logic [IDX_W-1:0] home;
  } req_t;

  typedef struct packed {
    logic success;
    logic table_full;
  } rsp_t;

  // One byte of reflected CRC-32.
  function automatic logic [31:0] crc32_byte(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ 32'hEDB88320) : (r >> 1);
    end
    return r;
  endfunction

endpackage

### hw/rtl/linear_probe_hash_set.sv
// Linear-probing hash set of 64-bit keys (find / insert / remove), up to
// 1024 slots. The front hashes a request by byte-wise CRC-32, reduces it
// bit-serially modulo the table size and hands it off; the back then walks
// probes (status/key memory read, compare) and commits insert or remove in
// a final write state; a two-entry request queue lets the front hash the
// next request while the back walks. Throughput is set by the slower of the
// two; full stays high while the front works on an accepted request.
// Results wait in a one-entry output register. After reset the back clears
// slot status to empty in one pass before it serves the first request; the
// front keeps accepting meanwhile until the queue backs up. Write the table
// size through cfg_we / cfg_wdata only while no request is in flight.
module linear_probe_hash_set (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  in_action,
  input  logic [63:0] in_key,
  output logic        empty,
  input  logic        pop,
  output logic        out_success,
  output logic        out_table_full,
  input  logic        cfg_we,
  input  logic [10:0] cfg_wdata
);
  logic [10:0] size_r, live;
  logic fe_busy, q_push, q_full, q_empty, q_pop, rsp_valid;
  lphs_pkg::req_t q_wreq, q_rreq;
  lphs_pkg::rsp_t rsp, out_r;
  logic out_v_r;

  // Clamp the size to 1..DEPTH.
  assign live = (size_r == '0) ? 11'd1 : (size_r > 11'd1024) ? 11'd1024 : size_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r  <= 11'd1024;
      out_v_r <= 1'b0;
    end else begin
      if (cfg_we) size_r <= cfg_wdata;
      // advance result into the output register; drop it on pop
      if (rsp_valid && !out_v_r) out_v_r <= 1'b1;
      else if (pop && out_v_r) out_v_r <= 1'b0;
    end
    if (rsp_valid && !out_v_r) out_r <= rsp;
  end

  assign full  = fe_busy;
  assign empty = !out_v_r;
  assign out_success    = out_r.success;
  assign out_table_full = out_r.table_full;

  lphs_front u_front (
    .clk, .rst_n, .push, .busy(fe_busy),
    .action(lphs_pkg::action_t'(in_action)), .key(in_key), .size(live),
    .q_push, .q_req(q_wreq), .q_full
  );

  lphs_queue u_queue (
    .clk, .rst_n, .wr(q_push), .wdata(q_wreq), .full(q_full),
    .rd(q_pop), .rdata(q_rreq), .empty(q_empty)
  );

  lphs_back u_back (
    .clk, .rst_n, .size(live), .q_empty, .q_req(q_rreq), .q_pop,
    .rsp_valid, .rsp, .rsp_full(out_v_r)
  );

  a_one_flag: assert property (@(posedge clk) disable iff (!rst_n)
    !empty |-> !(out_success && out_table_full))
    else $error("both success and full set");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty)
    else $error("result lost");
  a_live: assert property (@(posedge clk) disable iff (!rst_n)
    live != 11'd0 && live <= 11'd1024)
    else $error("size out of range");
endmodule

### hw/rtl/lphs_front.sv
// Front: hash the key one byte a cycle, then reduce modulo table size by
// repeated compare-and-subtract on a shifted divisor (one bit per cycle).
module lphs_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        push,
  output logic                        busy,
  input  lphs_pkg::action_t           action,
  input  logic [lphs_pkg::KEY_W-1:0]  key,
  input  logic [lphs_pkg::SIZE_W-1:0] size,
  output logic                        q_push,
  output lphs_pkg::req_t              q_req,
  input  logic                        q_full
);
  logic [1:0]  phase_r, phase_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [41:0] div_r, div_nxt;
  lphs_pkg::action_t act_r, act_nxt;
  logic [lphs_pkg::KEY_W-1:0] key_r, key_nxt;
  logic [31:0] rem;

  assign busy = (phase_r != 2'd0);
  assign rem = crc_r ^ 32'hFFFFFFFF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 2'd0;
    end else begin
      phase_r <= phase_nxt;
    end
    cnt_r <= cnt_nxt;
    crc_r <= crc_nxt;
    div_r <= div_nxt;
    act_r <= act_nxt;
    key_r <= key_nxt;
  end

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt   = cnt_r;
    crc_nxt   = crc_r;
    div_nxt   = div_r;
    act_nxt   = act_r;
    key_nxt   = key_r;
    q_push    = 1'b0;
    q_req.action = act_r;
    q_req.key    = key_r;
    q_req.home   = crc_r[lphs_pkg::IDX_W-1:0];
    case (phase_r)
      2'd0: begin
        if (push) begin
          act_nxt   = action;
          key_nxt   = key;
          crc_nxt   = 32'hFFFFFFFF;
          cnt_nxt   = 4'd0;
          phase_nxt = 2'd1;
        end
      end
      2'd1: begin
        crc_nxt = lphs_pkg::crc32_byte(crc_r, key_r[cnt_r[2:0]*8 +: 8]);
        cnt_nxt = cnt_r + 4'd1;
        if (cnt_r == 4'd7) begin
          div_nxt   = {size, 31'd0};
          cnt_nxt   = 4'd0;
          phase_nxt = 2'd2;
        end
      end
      2'd2: begin
        // restoring reduction of the inverted CRC, 32 steps
        if ({10'd0, rem} >= div_r) begin
          crc_nxt = (rem - div_r[31:0]) ^ 32'hFFFFFFFF;
        end
        div_nxt = div_r >> 1;
        if (div_r[41:0] < {31'd0, size}) begin
          crc_nxt   = rem;
          phase_nxt = 2'd3;
        end
      end
      2'd3: begin
        if (!q_full) begin
          q_push    = 1'b1;
          phase_nxt = 2'd0;
        end
      end
      default: phase_nxt = 2'd0;
    endcase
  end
endmodule

### hw/rtl/lphs_queue.sv
module lphs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  lphs_pkg::req_t   wdata,
  output logic             full,
  input  logic             rd,
  output lphs_pkg::req_t   rdata,
  output logic             empty
);
  lphs_pkg::req_t mem_r [lphs_pkg::QDEPTH];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  assign full  = (cnt_r == 2'(lphs_pkg::QDEPTH));
  assign empty = (cnt_r == 2'd0);
  assign rdata = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (wr && !full) wp_r <= ~wp_r;
      if (rd && !empty) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(wr && !full) - 2'(rd && !empty);
    end
    if (wr && !full) mem_r[wp_r] <= wdata;
  end
endmodule

### hw/rtl/lphs_back.sv
// Back: walk slots through the status and key memories, each probe a read
// state then a check state; a final write state commits insert or remove.
// After reset, clear every status entry to empty, one slot per cycle.
module lphs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [lphs_pkg::SIZE_W-1:0] size,
  input  logic                        q_empty,
  input  lphs_pkg::req_t              q_req,
  output logic                        q_pop,
  output logic                        rsp_valid,
  output lphs_pkg::rsp_t              rsp,
  input  logic                        rsp_full
);
  lphs_pkg::slot_st_t stat_mem [lphs_pkg::DEPTH];
  logic [lphs_pkg::KEY_W-1:0] key_mem [lphs_pkg::DEPTH];

  lphs_pkg::bk_state_t st_r, st_nxt;
  lphs_pkg::req_t      req_r, req_nxt;
  logic [lphs_pkg::IDX_W-1:0] h_r, h_nxt, free_r, free_nxt, wa;
  logic [lphs_pkg::IDX_W-1:0] clr_r, clr_nxt;
  logic [lphs_pkg::SIZE_W-1:0] steps_r, steps_nxt, occ_r, occ_nxt;
  logic free_ok_r, free_ok_nxt;
  lphs_pkg::rsp_t rsp_r, rsp_nxt;
  lphs_pkg::slot_st_t st_rd_r, ws, cur_st;
  logic [lphs_pkg::KEY_W-1:0] key_rd_r;
  logic we;
  logic [lphs_pkg::IDX_W-1:0] h_inc;
  logic last;

  assign cur_st = st_rd_r;
  assign h_inc  = ({1'b0, h_r} + 11'd1 == size) ? '0 : h_r + 1'b1;
  assign last   = (steps_r + 11'd1 == size);
  assign rsp_valid = (st_r == lphs_pkg::BK_DONE);
  assign rsp       = rsp_r;

  always_ff @(posedge clk) begin
    st_rd_r    <= stat_mem[h_r];
    key_rd_r   <= key_mem[h_r];
    if (we) begin
      stat_mem[wa] <= ws;
      if (ws == lphs_pkg::ST_USED) key_mem[wa] <= req_r.key;
    end
    if (!rst_n) begin
      st_r    <= lphs_pkg::BK_CLEAR;
      clr_r   <= '0;
      occ_r   <= '0;
    end else begin
      st_r  <= st_nxt;
      clr_r <= clr_nxt;
      occ_r <= occ_nxt;
    end
    req_r     <= req_nxt;
    h_r       <= h_nxt;
    free_r    <= free_nxt;
    free_ok_r <= free_ok_nxt;
    steps_r   <= steps_nxt;
    rsp_r     <= rsp_nxt;
  end

  always_comb begin
    st_nxt = st_r;
    req_nxt = req_r;
    h_nxt = h_r;
    free_nxt = free_r;
    free_ok_nxt = free_ok_r;
    steps_nxt = steps_r;
    rsp_nxt = rsp_r;
    occ_nxt = occ_r;
    clr_nxt = clr_r;
    q_pop = 1'b0;
    we = 1'b0;
    wa = h_r;
    ws = lphs_pkg::ST_USED;
    case (st_r)
      lphs_pkg::BK_CLEAR: begin
        we = 1'b1;
        wa = clr_r;
        ws = lphs_pkg::ST_EMPTY;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == '1) st_nxt = lphs_pkg::BK_IDLE;
      end
      lphs_pkg::BK_IDLE: begin
        if (!q_empty) begin
          q_pop = 1'b1;
          req_nxt = q_req;
          h_nxt = q_req.home;
          steps_nxt = '0;
          free_ok_nxt = 1'b0;
          rsp_nxt = '0;
          st_nxt = (q_req.action == lphs_pkg::ACT_NONE) ? lphs_pkg::BK_DONE
                                                         : lphs_pkg::BK_READ;
        end
      end
      lphs_pkg::BK_READ: st_nxt = lphs_pkg::BK_CHECK;
      lphs_pkg::BK_CHECK: begin
        // remember the first non-used slot for insert
        if (cur_st != lphs_pkg::ST_USED && !free_ok_r) begin
          free_ok_nxt = 1'b1;
          free_nxt = h_r;
        end
        if (cur_st == lphs_pkg::ST_USED && key_rd_r == req_r.key) begin
          rsp_nxt.success = (req_r.action != lphs_pkg::ACT_INSERT);
          st_nxt = (req_r.action == lphs_pkg::ACT_REMOVE) ? lphs_pkg::BK_WRITE
                                                           : lphs_pkg::BK_DONE;
        end else if (cur_st == lphs_pkg::ST_EMPTY || last) begin
          // absent
          st_nxt = (req_r.action == lphs_pkg::ACT_INSERT) ? lphs_pkg::BK_WRITE
                                                           : lphs_pkg::BK_DONE;
        end else begin
          h_nxt = h_inc;
          steps_nxt = steps_r + 11'd1;
          st_nxt = lphs_pkg::BK_READ;
        end
      end
      lphs_pkg::BK_WRITE: begin
        st_nxt = lphs_pkg::BK_DONE;
        if (req_r.action == lphs_pkg::ACT_REMOVE) begin
          we = 1'b1;
          ws = lphs_pkg::ST_DELETED;
          if (occ_r != '0) occ_nxt = occ_r - 11'd1;
        end else if ({occ_r, 1'b0} >= {1'b0, size} || !free_ok_r) begin
          rsp_nxt.table_full = 1'b1;
        end else begin
          we = 1'b1;
          wa = free_r;
          occ_nxt = occ_r + 11'd1;
          rsp_nxt.success = 1'b1;
        end
      end
      lphs_pkg::BK_DONE: if (!rsp_full) st_nxt = lphs_pkg::BK_IDLE;
      default: st_nxt = lphs_pkg::BK_IDLE;
    endcase
  end
endmodule

### sim/tb.sv
module tb;

  localparam int unsigned IDLE_LIMIT = 20000;
  localparam int unsigned POOL_N     = 48;
  localparam int unsigned HOLD_LEN   = 400;

  // Clock and block ports; every input starts at a known value.
  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        push           = 1'b0;
  logic        full;
  logic [1:0]  in_action      = lphs_pkg::ACT_FIND;
  logic [63:0] in_key         = '0;
  logic        empty;
  logic        pop            = 1'b0;
  logic        out_success;
  logic        out_table_full;
  logic        cfg_we         = 1'b0;
  logic [10:0] cfg_wdata      = '0;

  linear_probe_hash_set dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .full          (full),
    .in_action     (in_action),
    .in_key        (in_key),
    .empty         (empty),
    .pop           (pop),
    .out_success   (out_success),
    .out_table_full(out_table_full),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Shadow copy of the set: slot status, slot keys, occupancy and size.
  lphs_pkg::slot_st_t         shadow_status [lphs_pkg::DEPTH];
  logic [lphs_pkg::KEY_W-1:0] shadow_keys   [lphs_pkg::DEPTH];
  int unsigned      shadow_occ;
  logic [10:0]      shadow_size;

  // Answers still owed by the block, oldest first.
  lphs_pkg::rsp_t pending_answers[$];

  int unsigned mismatches;
  int unsigned sent_cnt, got_cnt, hit_cnt, full_cnt;
  int unsigned idle_cycles;
  bit          hold_wanted;
  int unsigned burst_left;

  logic [63:0] key_pool [POOL_N];

  typedef struct {
    lphs_pkg::action_t act;
    logic [63:0]       key;
    bit                known;
    bit                succ;
    bit                tfull;
  } dir_row_t;

  // Home slot: reflected CRC-32 over the key bytes, low byte first, bit-serial.
  function automatic int unsigned home_slot(logic [63:0] k, int unsigned n);
    logic [31:0] crc;
    logic        fb;
    crc = 32'hFFFF_FFFF;
    for (int i = 0; i < 64; i++) begin
      fb  = crc[0] ^ k[i];
      crc = crc >> 1;
      if (fb) crc = crc ^ 32'hEDB8_8320;
    end
    return (~crc) % n;
  endfunction

  function automatic int unsigned slots_live();
    if (shadow_size == 0) return 1;
    if (shadow_size > lphs_pkg::DEPTH) return lphs_pkg::DEPTH;
    return shadow_size;
  endfunction

  // Walk one lap from home; -1 when an empty slot or the lap end is reached.
  function automatic int find_slot(logic [63:0] k, int unsigned n);
    int unsigned h;
    h = home_slot(k, n);
    for (int unsigned i = 0; i < n; i++) begin
      if (shadow_status[h] == lphs_pkg::ST_EMPTY) return -1;
      if (shadow_status[h] == lphs_pkg::ST_USED && shadow_keys[h] == k) return h;
      h = (h + 1 == n) ? 0 : h + 1;
    end
    return -1;
  endfunction

  // Apply one request to the shadow set and return the answer it earns.
  function automatic lphs_pkg::rsp_t apply_request(lphs_pkg::action_t act, logic [63:0] k);
    lphs_pkg::rsp_t r;
    int unsigned    n, h;
    int             pos;
    r = '0;
    n = slots_live();
    case (act)
      lphs_pkg::ACT_FIND: begin
        r.success = (find_slot(k, n) >= 0);
      end
      lphs_pkg::ACT_INSERT: begin
        if (find_slot(k, n) < 0) begin
          r.table_full = 1'b1;
          if (2 * shadow_occ < n) begin
            h = home_slot(k, n);
            for (int unsigned i = 0; i < n; i++) begin
              if (shadow_status[h] != lphs_pkg::ST_USED) begin
                shadow_keys[h]   = k;
                shadow_status[h] = lphs_pkg::ST_USED;
                shadow_occ       = (shadow_occ + 1) & 11'h7FF;
                r.success        = 1'b1;
                r.table_full     = 1'b0;
                break;
              end
              h = (h + 1 == n) ? 0 : h + 1;
            end
          end
        end
      end
      lphs_pkg::ACT_REMOVE: begin
        pos = find_slot(k, n);
        if (pos >= 0) begin
          shadow_status[pos] = lphs_pkg::ST_DELETED;
          if (shadow_occ > 0) shadow_occ--;
          r.success = 1'b1;
        end
      end
      default: ;  // unused code: no change, all flags low
    endcase
    return r;
  endfunction

  // Offer one request; on acceptance queue its answer. A typed answer, when
  // given, replaces the shadow's but the shadow still advances.
  task automatic offer(lphs_pkg::action_t act, logic [63:0] k, bit known = 0,
                       bit succ = 0, bit tfull = 0);
    lphs_pkg::rsp_t r;
    in_action <= act;
    in_key    <= k;
    push      <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    r = apply_request(act, k);
    if (known) begin
      r.success    = succ;
      r.table_full = tfull;
    end
    pending_answers.insert(pending_answers.size(), r);
    sent_cnt++;
    // Bursts of random length, then usually a random gap with push low.
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 30)) @(posedge clk);
      end
    end
  endtask

  // Change the table size only once every owed answer has come back.
  task automatic set_table_size(logic [10:0] v);
    push <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we      <= 1'b0;
    shadow_size  = v;
  endtask

  function automatic logic [63:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, POOL_N - 1)];
    return {$urandom(), $urandom()};
  endfunction

  function automatic lphs_pkg::action_t pick_action();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return lphs_pkg::ACT_INSERT;
    if (p < 70) return lphs_pkg::ACT_FIND;
    if (p < 95) return lphs_pkg::ACT_REMOVE;
    return lphs_pkg::ACT_NONE;
  endfunction

  // Receiver: check each popped answer, then choose the next pop level.
  always @(posedge clk) begin : answer_side
    int unsigned    stall_phase;
    int unsigned    hold_left;
    lphs_pkg::rsp_t want;
    if (pop && !empty) begin
      got_cnt++;
      if (out_success)    hit_cnt++;
      if (out_table_full) full_cnt++;
      if (pending_answers.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("answer with nothing owed: success=%0b table_full=%0b",
                   out_success, out_table_full);
      end else begin
        want = pending_answers.pop_front();
        if (out_success !== want.success || out_table_full !== want.table_full) begin
          mismatches++;
          if (mismatches <= 10)
            $display("answer %0d: expected success=%0b table_full=%0b, got %0b %0b",
                     got_cnt, want.success, want.table_full, out_success,
                     out_table_full);
        end
      end
    end
    // Long hold-off on request, so the input side backs up and stalls.
    if (hold_wanted) begin
      hold_wanted = 0;
      hold_left   = HOLD_LEN;
    end
    stall_phase = (stall_phase + 1) % 600;
    if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (stall_phase < 200) begin
      pop <= 1'b1;                               // free-running stretch
    end else begin
      pop <= ($urandom_range(0, 2) == 0);        // choppy stretch
    end
  end

  // Watchdog: end the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no request or answer moved for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin : stimulus
    dir_row_t    rows[$];
    logic [10:0] sizes[$];
    for (int i = 0; i < lphs_pkg::DEPTH; i++) shadow_status[i] = lphs_pkg::ST_EMPTY;
    shadow_occ  = 0;
    shadow_size = 11'd1024;
    burst_left  = 1;
    for (int i = 0; i < POOL_N; i++) key_pool[i] = {$urandom(), $urandom()};
    key_pool[0] = '0;
    key_pool[1] = '1;

    // Directed rows; typed answers only where they are obvious after reset.
    rows = '{
      '{lphs_pkg::ACT_FIND,   64'h0,                  1, 0, 0},
      '{lphs_pkg::ACT_INSERT, 64'h0,                  1, 1, 0},
      '{lphs_pkg::ACT_INSERT, 64'h0,                  1, 0, 0},  // already present
      '{lphs_pkg::ACT_FIND,   64'h0,                  1, 1, 0},
      '{lphs_pkg::ACT_REMOVE, 64'h0,                  1, 1, 0},
      '{lphs_pkg::ACT_REMOVE, 64'h0,                  1, 0, 0},  // already gone
      '{lphs_pkg::ACT_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0},
      '{lphs_pkg::ACT_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0},
      '{lphs_pkg::ACT_NONE,   64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 0},  // unused action code
      '{lphs_pkg::ACT_FIND,   64'hFFFF_FFFF_FFFF_FFFF, 1, 1, 0},
      '{lphs_pkg::ACT_INSERT, 64'h0,                  1, 1, 0},
      '{lphs_pkg::ACT_INSERT, 64'h8000_0000_0000_0000, 0, 0, 0},
      '{lphs_pkg::ACT_INSERT, 64'h1,                  0, 0, 0},
      '{lphs_pkg::ACT_INSERT, 64'h0123_4567_89AB_CDEF, 0, 0, 0},
      '{lphs_pkg::ACT_INSERT, 64'hFEDC_BA98_7654_3210, 0, 0, 0},
      '{lphs_pkg::ACT_FIND,   64'h1,                  0, 0, 0},
      '{lphs_pkg::ACT_REMOVE, 64'h8000_0000_0000_0000, 0, 0, 0},
      '{lphs_pkg::ACT_FIND,   64'h0123_4567_89AB_CDEF, 0, 0, 0},
      '{lphs_pkg::ACT_REMOVE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0}
    };

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i])
      offer(rows[i].act, rows[i].key, rows[i].known, rows[i].succ, rows[i].tfull);

    // Size sweep: one slot, tiny tables that fill and fill with tombstones,
    // zero (acts as one), oversize (saturates), full depth, and a last tiny table.
    sizes = '{11'd1, 11'd2, 11'd7, 11'd2047, 11'd16, 11'd0, 11'd64, 11'd1024, 11'd3};
    foreach (sizes[p]) begin
      set_table_size(sizes[p]);
      if (p == 3) hold_wanted = 1;
      repeat (125) offer(pick_action(), pick_key());
    end

    push <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("covered %0d requests over %0d table sizes: %0d answers, %0d hits, %0d refused full",
             sent_cnt, sizes.size() + 1, got_cnt, hit_cnt, full_cnt);
    $display("mismatches: %0d", mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
